/* src/hef_pkg.sv */
package hef_pkg;

  localparam int EP_W    = 3;
  localparam int SCORE_W = 11;
  localparam int RANK_W  = 8;
  localparam int CNT_W   = 4;
  localparam int STAT_W  = 3;
  localparam int HEV_W   = 2;

  // command codes
  localparam logic [1:0] CMD_BEGIN   = 2'd0;
  localparam logic [1:0] CMD_OUTCOME = 2'd1;
  localparam logic [1:0] CMD_RANK    = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_TRY       = 3'd0;
  localparam logic [STAT_W-1:0] ST_SERVED    = 3'd1;
  localparam logic [STAT_W-1:0] ST_EXHAUSTED = 3'd2;
  localparam logic [STAT_W-1:0] ST_RANK      = 3'd3;
  localparam logic [STAT_W-1:0] ST_ERROR     = 3'd4;

  // health events
  localparam logic [HEV_W-1:0] HEV_NONE      = 2'd0;
  localparam logic [HEV_W-1:0] HEV_DEGRADED  = 2'd1;
  localparam logic [HEV_W-1:0] HEV_RECOVERED = 2'd2;

  // configuration register indexes
  localparam logic CFG_FORCE = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  localparam logic [SCORE_W-1:0] SCORE_MAX = 11'd2047;
  localparam logic [SCORE_W-1:0] BAND      = 11'd128;
  localparam logic [SCORE_W:0]   FAIL_ADD  = 12'd256;

  typedef struct packed {
    logic latch;
    logic err;
    logic rank_wr;
    logic update;
    logic scan_start;
    logic scan_step;
    logic resolve;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       open;
    logic       fail_go;
    logic       scan_last;
    logic       out_free;
  } ctl_stat_t;

endpackage

/* src/hef_controller.sv */
module hef_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  hef_pkg::ctl_stat_t stat,
  output hef_pkg::ctl_cmd_t  ctl
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DISPATCH = 6'b000010,
    S_SCAN     = 6'b000100,
    S_DRAIN    = 6'b001000,
    S_RESOLVE  = 6'b010000,
    S_FINISH   = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctl = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch  = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.cmd == hef_pkg::CMD_RANK) begin
          ctl.rank_wr = 1'b1;
          state_next  = S_FINISH;
        end else if (stat.cmd == hef_pkg::CMD_BEGIN && !stat.open) begin
          ctl.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else if (stat.cmd == hef_pkg::CMD_OUTCOME && stat.open) begin
          ctl.update = 1'b1;
          if (stat.fail_go) begin
            ctl.scan_start = 1'b1;
            state_next     = S_SCAN;
          end else begin
            state_next = S_FINISH;
          end
        end else begin
          ctl.err    = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (stat.scan_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_RESOLVE;
      end
      S_RESOLVE: begin
        ctl.resolve = 1'b1;
        state_next  = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

/* src/hef_datapath.sv */
module hef_datapath #(
  parameter int DEPTH       = 8,
  parameter int RANK_WEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [hef_pkg::CNT_W-1:0]     cfg_data,
  input  logic [1:0]                    command,
  input  logic                          attempt_ok,
  input  logic [hef_pkg::EP_W-1:0]      target_endpoint,
  input  logic [hef_pkg::RANK_W-1:0]    rank_value,
  input  hef_pkg::ctl_cmd_t             ctl,
  output hef_pkg::ctl_stat_t            stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hef_pkg::STAT_W-1:0]    status,
  output logic [hef_pkg::EP_W-1:0]      endpoint,
  output logic                          probe_taken,
  output logic                          failover_taken,
  output logic                          served_by_non_primary,
  output logic [hef_pkg::HEV_W-1:0]     health_event,
  output logic [hef_pkg::EP_W-1:0]      health_endpoint
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EFF_W = $clog2(255 * RANK_WEIGHT + 2048);
  localparam int SW    = hef_pkg::SCORE_W;
  localparam int RW    = hef_pkg::RANK_W;
  localparam int EW    = hef_pkg::EP_W;
  localparam int CW    = hef_pkg::CNT_W;

  // configuration
  logic          pin_primary;
  logic [CW-1:0] endpoint_count;

  // latched item
  logic [1:0]    cmd_q;
  logic          ok_q;
  logic [EW-1:0] tgt_q;
  logic [RW-1:0] rv_q;

  logic [SW-1:0] score [DEPTH];
  logic [RW-1:0] rank  [DEPTH];

  logic          request_open;
  logic          attempt_number;
  logic [1:0]    probe_counter;
  logic [EW-1:0] current_endpoint;
  logic [EW-1:0] first_endpoint;

  // scan and compare stage
  logic [IDX_W-1:0] scan_idx;
  logic             skip_en;
  logic             p_vld;
  logic             p_take;
  logic [IDX_W-1:0] p_idx;
  logic [EFF_W-1:0] p_eff;
  logic [RW-1:0]    p_rank;
  logic [SW-1:0]    p_score;
  logic             have_best;
  logic [IDX_W-1:0] best_idx;
  logic [EFF_W-1:0] best_eff;
  logic [IDX_W-1:0] pref_idx;
  logic [RW-1:0]    pref_rank;
  logic [SW-1:0]    pref_score;

  // result under construction
  logic [hef_pkg::STAT_W-1:0] res_status;
  logic [EW-1:0]              res_endpoint;
  logic                       res_probe;
  logic                       res_fail;
  logic                       res_nonprim;
  logic [hef_pkg::HEV_W-1:0]  res_hev;
  logic [EW-1:0]              res_hend;

  logic [CW-1:0]    n_act;
  logic [IDX_W-1:0] rd_addr;
  logic [SW-1:0]    rd_score;
  logic [RW-1:0]    rd_rank;
  logic             cur_in;
  logic             tgt_in;
  logic [SW+2:0]    was7;
  logic [SW:0]      sum;
  logic [SW-1:0]    now_score;
  logic             went_bad;
  logic             went_good;
  logic             fail_go;
  logic [1:0]       pc_inc;
  logic             multi;
  logic             probe_hit;
  logic [IDX_W-1:0] ep_begin;

  always_comb begin
    if (endpoint_count == '0) n_act = CW'(1);
    else if (endpoint_count > CW'(DEPTH)) n_act = CW'(DEPTH);
    else n_act = endpoint_count;
  end

  assign rd_addr  = ctl.update ? current_endpoint[IDX_W-1:0] : scan_idx;
  assign rd_score = score[rd_addr];
  assign rd_rank  = rank[rd_addr];
  assign cur_in   = ({1'b0, current_endpoint} < CW'(DEPTH));
  assign tgt_in   = ({1'b0, tgt_q} < CW'(DEPTH));

  // score * 7 / 8, plus the failure penalty, saturated
  assign was7      = ({3'b000, rd_score} << 3) - {3'b000, rd_score};
  assign sum       = {1'b0, was7[SW+2:3]} + (ok_q ? '0 : hef_pkg::FAIL_ADD);
  assign now_score = (sum > {1'b0, hef_pkg::SCORE_MAX}) ? hef_pkg::SCORE_MAX : sum[SW-1:0];
  assign went_bad  = !ok_q && rd_score < hef_pkg::BAND && now_score >= hef_pkg::BAND;
  assign went_good = ok_q && rd_score >= hef_pkg::BAND && now_score < hef_pkg::BAND;

  assign fail_go = !ok_q && !attempt_number && n_act >= CW'(2) && !pin_primary;

  // begin: score pick, or the rank-preferred endpoint when pinned or on a probe turn
  assign pc_inc    = probe_counter + 2'd1;
  assign multi     = !pin_primary && n_act > CW'(1);
  assign probe_hit = multi && pc_inc == 2'd0 && pref_score != '0;
  assign ep_begin  = (pin_primary || probe_hit) ? pref_idx : best_idx;

  assign stat.cmd       = cmd_q;
  assign stat.open      = request_open;
  assign stat.fail_go   = fail_go;
  assign stat.scan_last = ({{(CW-IDX_W){1'b0}}, scan_idx} == n_act - CW'(1));
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_primary    <= 1'b0;
      endpoint_count <= CW'(1);
    end else if (cfg_write) begin
      if (cfg_index == hef_pkg::CFG_FORCE) pin_primary <= cfg_data[0];
      else endpoint_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_q <= command;
      ok_q  <= attempt_ok;
      tgt_q <= target_endpoint;
      rv_q  <= rank_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        score[i] <= '0;
        rank[i]  <= '0;
      end
    end else begin
      if (ctl.update && cur_in) score[current_endpoint[IDX_W-1:0]] <= now_score;
      if (ctl.rank_wr && tgt_in) rank[tgt_q[IDX_W-1:0]] <= rv_q;
    end
  end

  // scan: one entry a cycle into the effective-score register, compare next cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld     <= 1'b0;
      have_best <= 1'b0;
    end else begin
      p_vld <= ctl.scan_step;
      if (ctl.scan_start) begin
        have_best <= 1'b0;
      end else if (p_vld && p_take && (!have_best || p_eff < best_eff)) begin
        have_best <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan_start) begin
      scan_idx <= '0;
      skip_en  <= (cmd_q == hef_pkg::CMD_OUTCOME);
    end else if (ctl.scan_step) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    if (ctl.scan_step) begin
      p_idx   <= scan_idx;
      p_take  <= !(skip_en && EW'(scan_idx) == first_endpoint);
      p_eff   <= EFF_W'(rd_rank) * EFF_W'(RANK_WEIGHT) + EFF_W'(rd_score);
      p_rank  <= rd_rank;
      p_score <= rd_score;
    end
    if (p_vld) begin
      if (p_take && (!have_best || p_eff < best_eff)) begin
        best_idx <= p_idx;
        best_eff <= p_eff;
      end
      if (p_idx == '0 || p_rank < pref_rank) begin
        pref_idx   <= p_idx;
        pref_rank  <= p_rank;
        pref_score <= p_score;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      request_open     <= 1'b0;
      attempt_number   <= 1'b0;
      probe_counter    <= '0;
      current_endpoint <= '0;
      first_endpoint   <= '0;
    end else begin
      if (ctl.update && !fail_go) request_open <= 1'b0;
      if (ctl.resolve) begin
        if (cmd_q == hef_pkg::CMD_BEGIN) begin
          if (multi) probe_counter <= pc_inc;
          request_open     <= 1'b1;
          attempt_number   <= 1'b0;
          current_endpoint <= EW'(ep_begin);
          first_endpoint   <= EW'(ep_begin);
        end else begin
          attempt_number   <= 1'b1;
          current_endpoint <= EW'(best_idx);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      res_status   <= hef_pkg::ST_ERROR;
      res_endpoint <= '0;
      res_probe    <= 1'b0;
      res_fail     <= 1'b0;
      res_nonprim  <= 1'b0;
      res_hev      <= hef_pkg::HEV_NONE;
      res_hend     <= '0;
    end
    if (ctl.err) res_status <= hef_pkg::ST_ERROR;
    if (ctl.rank_wr) begin
      res_status   <= hef_pkg::ST_RANK;
      res_endpoint <= tgt_q;
    end
    if (ctl.update) begin
      res_status   <= ok_q ? hef_pkg::ST_SERVED : hef_pkg::ST_EXHAUSTED;
      res_endpoint <= current_endpoint;
      res_nonprim  <= ok_q && current_endpoint != '0;
      if (cur_in && went_bad) begin
        res_hev  <= hef_pkg::HEV_DEGRADED;
        res_hend <= current_endpoint;
      end else if (cur_in && went_good) begin
        res_hev  <= hef_pkg::HEV_RECOVERED;
        res_hend <= current_endpoint;
      end
    end
    if (ctl.resolve) begin
      res_status <= hef_pkg::ST_TRY;
      if (cmd_q == hef_pkg::CMD_BEGIN) begin
        res_endpoint <= EW'(ep_begin);
        res_probe    <= probe_hit && pref_idx != best_idx;
      end else begin
        res_endpoint <= EW'(best_idx);
        res_fail     <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      status                <= res_status;
      endpoint              <= res_endpoint;
      probe_taken           <= res_probe;
      failover_taken        <= res_fail;
      served_by_non_primary <= res_nonprim;
      health_event          <= res_hev;
      health_endpoint       <= res_hend;
    end
  end

endmodule

/* src/health_scored_endpoint_failover.sv */
// Endpoint selector with a rank and a decaying 11-bit failure score per endpoint.
// One item is taken at a time. Set-rank, served, exhausted and protocol-error
// items go from the dispatch state to the finish state, where the result is
// loaded for output; a begin, and a failed first attempt that names an
// alternate, pass through the scan, drain and resolve states first, because the
// selection walks the rank and score tables of the endpoints in use one entry
// per cycle through a single read port and a registered effective-score compare.
// The input is ready again in the cycle after the result is loaded. A finished
// result sits in the output register until its transfer; the next item can be
// taken meanwhile, and waits in the finish state until the register is free.
// Configuration writes take effect at once and belong in idle periods only.
module health_scored_endpoint_failover #(
  parameter int MAX_ENDPOINTS = 8,
  parameter int RANK_WEIGHT   = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic                       cfg_index,
  input  logic [hef_pkg::CNT_W-1:0]  cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 command,
  input  logic                       attempt_ok,
  input  logic [hef_pkg::EP_W-1:0]   target_endpoint,
  input  logic [hef_pkg::RANK_W-1:0] rank_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [hef_pkg::STAT_W-1:0] status,
  output logic [hef_pkg::EP_W-1:0]   endpoint,
  output logic                       probe_taken,
  output logic                       failover_taken,
  output logic                       served_by_non_primary,
  output logic [hef_pkg::HEV_W-1:0]  health_event,
  output logic [hef_pkg::EP_W-1:0]   health_endpoint
);

  // endpoint indexes are three bits wide, so at most eight entries are stored
  localparam int DEPTH = (MAX_ENDPOINTS < 8) ? MAX_ENDPOINTS : 8;

  hef_pkg::ctl_cmd_t  ctl;
  hef_pkg::ctl_stat_t stat;

  hef_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  hef_datapath #(
    .DEPTH       (DEPTH),
    .RANK_WEIGHT (RANK_WEIGHT)
  ) u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .cfg_write             (cfg_write),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data),
    .command               (command),
    .attempt_ok            (attempt_ok),
    .target_endpoint       (target_endpoint),
    .rank_value            (rank_value),
    .ctl                   (ctl),
    .stat                  (stat),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .status                (status),
    .endpoint              (endpoint),
    .probe_taken           (probe_taken),
    .failover_taken        (failover_taken),
    .served_by_non_primary (served_by_non_primary),
    .health_event          (health_event),
    .health_endpoint       (health_endpoint)
  );

endmodule

/* test/health_scored_endpoint_failover_tb.sv */
module health_scored_endpoint_failover_tb;

  localparam int N_SLOTS      = 8;
  localparam int WEIGHT       = 4096;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT        = 1000000;
  localparam int PHASE_ITEMS  = 170;
  localparam int N_PHASES     = 12;

  // no command is assigned to the fourth code
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam bit         PIN_PLAN   [7] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
  localparam logic [3:0] COUNT_PLAN [7] = '{4'd2, 4'd8, 4'd8, 4'd0, 4'd1, 4'd15, 4'd3};

  typedef struct packed {
    logic [hef_pkg::STAT_W-1:0] status;
    logic [hef_pkg::EP_W-1:0]   ep;
    logic                       probe;
    logic                       failover;
    logic                       non_primary;
    logic [hef_pkg::HEV_W-1:0]  hev;
    logic [hef_pkg::EP_W-1:0]   hev_ep;
  } selection_t;

  class selection_scoreboard;
    logic [hef_pkg::SCORE_W-1:0] score [N_SLOTS];
    logic [hef_pkg::RANK_W-1:0]  rank  [N_SLOTS];
    logic [1:0]                  probe_cnt;
    bit                          req_open;
    bit                          second_try;
    int                          cur_ep;
    int                          first_ep;
    bit                          force_pin;
    logic [hef_pkg::CNT_W-1:0]   count_reg;
    selection_t                  due_selections [$];
    int                          failures;

    function new();
      for (int i = 0; i < N_SLOTS; i++) begin
        score[i] = '0;
        rank[i]  = '0;
      end
      probe_cnt  = '0;
      req_open   = 1'b0;
      second_try = 1'b0;
      cur_ep     = 0;
      first_ep   = 0;
      force_pin  = 1'b0;
      count_reg  = 4'd1;
      failures   = 0;
    endfunction

    function void write_reg(logic idx, logic [hef_pkg::CNT_W-1:0] data);
      if (idx == hef_pkg::CFG_FORCE) force_pin = data[0];
      else count_reg = data;
    endfunction

    function int in_use();
      int n;
      n = count_reg;
      if (n < 1) n = 1;
      if (n > N_SLOTS) n = N_SLOTS;
      return n;
    endfunction

    function longint cost(int i);
      return longint'(rank[i]) * WEIGHT + longint'(score[i]);
    endfunction

    // cheapest endpoint other than skip, lowest index on ties
    function int cheapest(int n, int skip);
      int  best;
      bit  have;
      best = 0;
      have = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (i == skip) continue;
        if (!have || cost(i) < cost(best)) begin
          best = i;
          have = 1'b1;
        end
      end
      return best;
    endfunction

    function int preferred(int n);
      int best;
      best = 0;
      for (int i = 1; i < n; i++)
        if (rank[i] < rank[best]) best = i;
      return best;
    endfunction

    function void note_request_item(logic [1:0] cmd, logic ok,
                                    logic [hef_pkg::EP_W-1:0] tgt,
                                    logic [hef_pkg::RANK_W-1:0] rv);
      selection_t r;
      int         n, ep, pref, was, now, nx;
      r = '0;
      n = in_use();
      if (cmd == hef_pkg::CMD_BEGIN && !req_open) begin
        if (force_pin) begin
          ep = preferred(n);
        end else begin
          ep = cheapest(n, n);
          if (n > 1) begin
            probe_cnt = probe_cnt + 2'd1;
            if (probe_cnt == 2'd0) begin
              pref = preferred(n);
              if (score[pref] != '0) begin
                r.probe = (pref != ep);
                ep = pref;
              end
            end
          end
        end
        req_open   = 1'b1;
        second_try = 1'b0;
        cur_ep     = ep;
        first_ep   = ep;
        r.status   = hef_pkg::ST_TRY;
        r.ep       = hef_pkg::EP_W'(ep);
      end else if (cmd == hef_pkg::CMD_OUTCOME && req_open) begin
        was = score[cur_ep];
        now = was * 7 / 8 + (ok ? 0 : int'(hef_pkg::FAIL_ADD));
        if (now > int'(hef_pkg::SCORE_MAX)) now = int'(hef_pkg::SCORE_MAX);
        score[cur_ep] = hef_pkg::SCORE_W'(now);
        if (!ok && was < int'(hef_pkg::BAND) && now >= int'(hef_pkg::BAND)) begin
          r.hev    = hef_pkg::HEV_DEGRADED;
          r.hev_ep = hef_pkg::EP_W'(cur_ep);
        end else if (ok && was >= int'(hef_pkg::BAND) && now < int'(hef_pkg::BAND)) begin
          r.hev    = hef_pkg::HEV_RECOVERED;
          r.hev_ep = hef_pkg::EP_W'(cur_ep);
        end
        if (ok) begin
          r.status      = hef_pkg::ST_SERVED;
          r.ep          = hef_pkg::EP_W'(cur_ep);
          r.non_primary = (cur_ep != 0);
          req_open      = 1'b0;
        end else if (!second_try && n >= 2 && !force_pin) begin
          nx         = cheapest(n, first_ep);
          r.status   = hef_pkg::ST_TRY;
          r.ep       = hef_pkg::EP_W'(nx);
          r.failover = 1'b1;
          second_try = 1'b1;
          cur_ep     = nx;
        end else begin
          r.status = hef_pkg::ST_EXHAUSTED;
          r.ep     = hef_pkg::EP_W'(cur_ep);
          req_open = 1'b0;
        end
      end else if (cmd == hef_pkg::CMD_RANK) begin
        rank[tgt] = rv;
        r.status  = hef_pkg::ST_RANK;
        r.ep      = tgt;
      end else begin
        r.status = hef_pkg::ST_ERROR;
      end
      due_selections.push_back(r);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        failures++;
      end
    endfunction

    function void check_selection(logic [hef_pkg::STAT_W-1:0] st,
                                  logic [hef_pkg::EP_W-1:0] ep, logic pr,
                                  logic fo, logic np, logic [hef_pkg::HEV_W-1:0] hv,
                                  logic [hef_pkg::EP_W-1:0] hep);
      selection_t want;
      if (due_selections.size() == 0) begin
        $error("result with nothing outstanding: status %0d endpoint %0d", st, ep);
        failures++;
        return;
      end
      want = due_selections.pop_front();
      compare("status", 8'(want.status), 8'(st));
      compare("endpoint", 8'(want.ep), 8'(ep));
      compare("probe_taken", 8'(want.probe), 8'(pr));
      compare("failover_taken", 8'(want.failover), 8'(fo));
      compare("served_by_non_primary", 8'(want.non_primary), 8'(np));
      compare("health_event", 8'(want.hev), 8'(hv));
      compare("health_endpoint", 8'(want.hev_ep), 8'(hep));
    endfunction

    function int pending();
      return due_selections.size();
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        cfg_write = 1'b0;
  logic                        cfg_index = 1'b0;
  logic [hef_pkg::CNT_W-1:0]   cfg_data = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [1:0]                  command = '0;
  logic                        attempt_ok = 1'b0;
  logic [hef_pkg::EP_W-1:0]    target_endpoint = '0;
  logic [hef_pkg::RANK_W-1:0]  rank_value = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [hef_pkg::STAT_W-1:0]  status;
  logic [hef_pkg::EP_W-1:0]    endpoint;
  logic                        probe_taken;
  logic                        failover_taken;
  logic                        served_by_non_primary;
  logic [hef_pkg::HEV_W-1:0]   health_event;
  logic [hef_pkg::EP_W-1:0]    health_endpoint;

  selection_scoreboard sb = new();

  int cycles    = 0;
  int sent      = 0;
  int ok_pct    = 50;
  int hold_left = 0;
  int rdy_gap   = 0;
  bit calm      = 1'b0;
  bit hold_go   = 1'b0;

  health_scored_endpoint_failover #(
    .MAX_ENDPOINTS(N_SLOTS),
    .RANK_WEIGHT  (WEIGHT)
  ) u_dut (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_write            (cfg_write),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .command              (command),
    .attempt_ok           (attempt_ok),
    .target_endpoint      (target_endpoint),
    .rank_value           (rank_value),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .status               (status),
    .endpoint             (endpoint),
    .probe_taken          (probe_taken),
    .failover_taken       (failover_taken),
    .served_by_non_primary(served_by_non_primary),
    .health_event         (health_event),
    .health_endpoint      (health_endpoint)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("health_scored_endpoint_failover_tb failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [hef_pkg::RANK_W-1:0] pick_rank();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return hef_pkg::RANK_W'($urandom_range(0, 2));
    if (r < 90) return hef_pkg::RANK_W'($urandom);
    return (r < 95) ? 8'd0 : 8'd255;
  endfunction

  // result side
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_selection(status, endpoint, probe_taken, failover_taken,
                         served_by_non_primary, health_event, health_endpoint);
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_go) begin
      hold_go = 1'b0;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (rdy_gap > 0) begin
      rdy_gap   <= rdy_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) rdy_gap <= pick_gap();
    end
  end

  task automatic send_item(input logic [1:0] cmd, input logic ok,
                           input logic [hef_pkg::EP_W-1:0] tgt,
                           input logic [hef_pkg::RANK_W-1:0] rv);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    command         <= cmd;
    attempt_ok      <= ok;
    target_endpoint <= tgt;
    rank_value      <= rv;
    do @(posedge clk); while (!in_ready);
    sb.note_request_item(cmd, ok, tgt, rv);
    sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic configure(input logic [hef_pkg::CNT_W-1:0] pin_data,
                           input logic [hef_pkg::CNT_W-1:0] count_data);
    cfg_write <= 1'b1;
    cfg_index <= hef_pkg::CFG_FORCE;
    cfg_data  <= pin_data;
    @(posedge clk);
    sb.write_reg(hef_pkg::CFG_FORCE, pin_data);
    cfg_index <= hef_pkg::CFG_COUNT;
    cfg_data  <= count_data;
    @(posedge clk);
    sb.write_reg(hef_pkg::CFG_COUNT, count_data);
    cfg_write <= 1'b0;
  endtask

  task automatic send_noise();
    send_item(2'($urandom), 1'($urandom), hef_pkg::EP_W'($urandom),
              hef_pkg::RANK_W'($urandom));
  endtask

  task automatic send_rank();
    send_item(hef_pkg::CMD_RANK, 1'($urandom), hef_pkg::EP_W'($urandom), pick_rank());
  endtask

  // one request from begin until served or exhausted, with stray items now and then
  task automatic run_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      send_noise();
    end else if (r < 22) begin
      send_rank();
    end else begin
      send_item(hef_pkg::CMD_BEGIN, 1'($urandom), hef_pkg::EP_W'($urandom),
                hef_pkg::RANK_W'($urandom));
      while (sb.req_open) begin
        if ($urandom_range(0, 9) == 0)
          send_rank();
        else
          send_item(hef_pkg::CMD_OUTCOME, $urandom_range(0, 99) < ok_pct,
                    hef_pkg::EP_W'($urandom), hef_pkg::RANK_W'($urandom));
      end
    end
  endtask

  initial begin
    int phase_start;
    bit held;
    bit paused;
    held   = 1'b0;
    paused = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single endpoint after reset: protocol errors, rank extremes, exhaustion
    send_item(hef_pkg::CMD_OUTCOME, 1'b1, 3'd0, 8'd0);
    send_item(CMD_UNUSED, 1'b0, 3'd7, 8'd255);
    send_item(hef_pkg::CMD_RANK, 1'b0, 3'd7, 8'd255);
    send_item(hef_pkg::CMD_RANK, 1'b1, 3'd0, 8'd0);
    send_item(hef_pkg::CMD_BEGIN, 1'b0, 3'd0, 8'd0);
    send_item(hef_pkg::CMD_BEGIN, 1'b1, 3'd7, 8'd255);
    send_item(hef_pkg::CMD_OUTCOME, 1'b0, 3'd0, 8'd0);
    send_item(hef_pkg::CMD_BEGIN, 1'b0, 3'd0, 8'd0);
    send_item(hef_pkg::CMD_OUTCOME, 1'b1, 3'd7, 8'd255);

    // count above the table size: failover, rank write mid-request, probe on fourth begin
    settle();
    configure(4'd0, 4'd15);
    send_item(hef_pkg::CMD_BEGIN, 1'b0, 3'd0, 8'd0);
    send_item(hef_pkg::CMD_OUTCOME, 1'b0, 3'd0, 8'd0);
    send_item(hef_pkg::CMD_RANK, 1'b0, 3'd3, 8'd1);
    send_item(hef_pkg::CMD_OUTCOME, 1'b0, 3'd0, 8'd0);
    send_item(hef_pkg::CMD_BEGIN, 1'b0, 3'd0, 8'd0);
    send_item(hef_pkg::CMD_OUTCOME, 1'b1, 3'd0, 8'd0);
    send_item(hef_pkg::CMD_BEGIN, 1'b0, 3'd0, 8'd0);
    send_item(hef_pkg::CMD_OUTCOME, 1'b1, 3'd0, 8'd0);
    send_item(hef_pkg::CMD_BEGIN, 1'b0, 3'd0, 8'd0);
    send_item(hef_pkg::CMD_OUTCOME, 1'b1, 3'd0, 8'd0);

    // pinned primary: no failover on a failed attempt
    settle();
    configure(4'd15, 4'd8);
    send_item(hef_pkg::CMD_BEGIN, 1'b0, 3'd0, 8'd0);
    send_item(hef_pkg::CMD_OUTCOME, 1'b0, 3'd0, 8'd0);

    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      if (p < 7) configure({3'($urandom), PIN_PLAN[p]}, COUNT_PLAN[p]);
      else configure(hef_pkg::CNT_W'($urandom), hef_pkg::CNT_W'($urandom));
      calm        = (p % 4 == 3);
      ok_pct      = $urandom_range(25, 75);
      phase_start = sent;
      while (sent < phase_start + PHASE_ITEMS) begin
        // long receiver hold-off while items keep coming, so the input backs up
        if (p == 1 && !held && sent >= phase_start + 60) begin
          hold_go = 1'b1;
          held    = 1'b1;
        end
        if (p == 5 && !paused && sent >= phase_start + 80) begin
          settle();
          paused = 1'b1;
        end
        run_request();
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0)
      $display("health_scored_endpoint_failover_tb passed");
    else
      $display("health_scored_endpoint_failover_tb failed");
    $finish;
  end

endmodule
